// File: rtl/core/bli_pkg.sv
// shared types and constants for the bidirectional lut interpolator
package bli_pkg;

  localparam int TableDepth = 16;
  localparam int ValueWidth = 16;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int ProdW      = 2 * ValueWidth;
  localparam int QDepth     = 2;

  typedef logic [ValueWidth-1:0] val_t;
  typedef logic [IdxW-1:0]       idx_t;
  typedef logic [CntW-1:0]       cnt_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FWD  = 2'd1,
    OP_INV  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [0:0] REG_ENTRIES = 1'b0;

  // query handed from front to back
  typedef struct packed {
    logic inverse;
    val_t q;
    cnt_t n;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } bst_t;

endpackage

// File: rtl/core/bli_front.sv
// front end: accepts items, writes the table, queues queries
module bli_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          op,
  input  logic [3:0]          entry_index,
  input  bli_pkg::val_t       entry_fluence,
  input  bli_pkg::val_t       entry_position,
  input  bli_pkg::val_t       entry_voltage,
  input  bli_pkg::val_t       query_value,
  input  bli_pkg::cnt_t       n_cfg,
  input  logic                back_busy,
  output logic                tbl_we,
  output bli_pkg::idx_t       tbl_waddr,
  output bli_pkg::val_t       tbl_wf,
  output bli_pkg::val_t       tbl_wp,
  output bli_pkg::val_t       tbl_wv,
  output logic                job_valid,
  output bli_pkg::job_t       job,
  input  logic                job_take
);
  import bli_pkg::*;

  job_t        q_r [QDepth];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wp_r, rp_r;
  logic        acc, enq;
  cnt_t        n_sat;

  // a load holds off until the queue is empty and the back end is idle again
  assign full      = (cnt_r == 2'(QDepth)) ||
                     (op == OP_LOAD && (cnt_r != 2'd0 || back_busy));
  assign acc       = push && !full;
  assign n_sat     = (n_cfg > cnt_t'(TableDepth)) ? cnt_t'(TableDepth) : n_cfg;
  assign enq       = acc && (op == OP_FWD || op == OP_INV) && (n_sat != '0);
  assign tbl_we    = acc && (op == OP_LOAD) && ({1'b0, entry_index} < 5'(TableDepth));
  assign tbl_waddr = idx_t'(entry_index);
  assign tbl_wf    = entry_fluence;
  assign tbl_wp    = entry_position;
  assign tbl_wv    = entry_voltage;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign cnt_nxt   = cnt_r + 2'(enq) - 2'(job_take && job_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (enq) wp_r <= ~wp_r;
      if (job_take && job_valid) rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) q_r[wp_r] <= '{inverse: (op == OP_INV), q: query_value, n: n_sat};
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'(QDepth))
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) full |-> !enq)
    else $error("enqueue while full");
  assert property (@(posedge clk) disable iff (!rst_n) !job_valid |-> !(job_take && job_valid))
    else $error("dequeue from empty queue");

endmodule

// File: rtl/core/bli_back.sv
// back end: table scan, multiply and serial divide
module bli_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           tbl_we,
  input  bli_pkg::idx_t  tbl_waddr,
  input  bli_pkg::val_t  tbl_wf,
  input  bli_pkg::val_t  tbl_wp,
  input  bli_pkg::val_t  tbl_wv,
  input  logic           job_valid,
  input  bli_pkg::job_t  job,
  output logic           job_take,
  output logic           busy,
  output logic           res_valid,
  output bli_pkg::val_t  res_value,
  output logic           res_ok,
  output logic           res_inv,
  input  logic           res_pop
);
  import bli_pkg::*;

  val_t keys_m [TableDepth];
  val_t pos_m  [TableDepth];
  val_t volt_m [TableDepth];

  bst_t st_r, st_nxt;
  job_t job_r;
  cnt_t i_r;
  idx_t hi_r;
  logic have_lo_r, have_hi_r, exact_r, oob_r;
  val_t lo_in_r, lo_key_r;
  val_t ex_out_r;
  val_t lo_out_r, hi_out_r, hi_in_r;
  logic neg_r;
  logic [ProdW-1:0] prod_r;
  logic [ProdW-1:0] rem_r;
  logic [ProdW-1:0] quo_r;
  logic [$clog2(ProdW+1)-1:0] dc_r;
  val_t span_r;
  logic busy_r;
  val_t rv_r;
  logic rok_r, rinv_r, rvalid_r;

  val_t in_e, out_e, rd_in, rd_out;
  idx_t ia;
  logic [ProdW:0] trial;

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      keys_m[tbl_waddr] <= tbl_wf;
      pos_m[tbl_waddr]  <= tbl_wp;
      volt_m[tbl_waddr] <= tbl_wv;
    end
  end

  assign ia     = idx_t'(i_r);
  assign in_e   = job_r.inverse ? volt_m[ia] : keys_m[ia];
  assign out_e  = job_r.inverse ? keys_m[ia] : pos_m[ia];
  assign rd_in  = job_r.inverse ? volt_m[hi_r] : keys_m[hi_r];
  assign rd_out = job_r.inverse ? keys_m[hi_r] : pos_m[hi_r];
  assign trial  = {rem_r, quo_r[ProdW-1]} - {{(ProdW-ValueWidth+1){1'b0}}, span_r};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (job_valid && !rvalid_r) st_nxt = ST_SCAN;
      ST_SCAN:  if (i_r == job_r.n - cnt_t'(1)) st_nxt = ST_FETCH;
      ST_FETCH: st_nxt = ST_MUL;
      ST_MUL:   st_nxt = ST_DIV;
      ST_DIV:   if (dc_r == '0) st_nxt = ST_DONE;
      ST_DONE:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  assign job_take = (st_r == ST_IDLE) && job_valid && !rvalid_r;
  assign busy     = (st_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      rvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_DONE) rvalid_r <= 1'b1;
      else if (res_pop) rvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        job_r <= job;
        i_r <= '0;
        have_lo_r <= 1'b0;
        have_hi_r <= 1'b0;
        exact_r <= 1'b0;
        oob_r <= 1'b0;
      end
      ST_SCAN: begin
        i_r <= i_r + cnt_t'(1);
        if (i_r == '0 && in_e > job_r.q) oob_r <= 1'b1;
        if (i_r == job_r.n - cnt_t'(1) && in_e < job_r.q) oob_r <= 1'b1;
        if (!exact_r && in_e == job_r.q) begin
          exact_r <= 1'b1;
          ex_out_r <= out_e;
        end
        if (!have_hi_r && in_e > job_r.q) begin
          have_hi_r <= 1'b1;
          hi_r <= ia;
        end
        if (in_e < job_r.q && (!have_lo_r || in_e > lo_key_r)) begin
          have_lo_r <= 1'b1;
          lo_key_r <= in_e;
          lo_in_r <= in_e;
          lo_out_r <= out_e;
        end
      end
      ST_FETCH: begin
        hi_in_r  <= rd_in;
        hi_out_r <= rd_out;
      end
      ST_MUL: begin
        neg_r  <= hi_out_r < lo_out_r;
        span_r <= hi_in_r - lo_in_r;
        prod_r <= ProdW'((hi_out_r >= lo_out_r) ? hi_out_r - lo_out_r : lo_out_r - hi_out_r)
                  * ProdW'(job_r.q - lo_in_r);
        dc_r   <= ($clog2(ProdW+1))'(ProdW);
        rem_r  <= '0;
      end
      ST_DIV: begin
        if (dc_r == ($clog2(ProdW+1))'(ProdW)) quo_r <= prod_r;
        if (dc_r != ($clog2(ProdW+1))'(ProdW)) begin
          if (!trial[ProdW]) begin
            rem_r <= trial[ProdW-1:0];
            quo_r <= {quo_r[ProdW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[ProdW-2:0], quo_r[ProdW-1]};
            quo_r <= {quo_r[ProdW-2:0], 1'b0};
          end
        end
        if (dc_r == ($clog2(ProdW+1))'(ProdW)) dc_r <= dc_r;
        if (busy_r || dc_r != ($clog2(ProdW+1))'(ProdW)) dc_r <= dc_r - 1'b1;
      end
      ST_DONE: begin
        rinv_r <= job_r.inverse;
        if (oob_r) begin
          rok_r <= 1'b0; rv_r <= '0;
        end else if (exact_r) begin
          rok_r <= 1'b1; rv_r <= ex_out_r;
        end else if (!have_lo_r || !have_hi_r) begin
          rok_r <= 1'b0; rv_r <= '0;
        end else begin
          rok_r <= 1'b1;
          rv_r  <= neg_r ? lo_out_r - val_t'(quo_r) : lo_out_r + val_t'(quo_r);
        end
      end
      default: ;
    endcase
  end

  // the divide state first loads the dividend, then each later divide step shifts in a quotient bit
  always_ff @(posedge clk) begin
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= (st_r == ST_DIV) && (dc_r == ($clog2(ProdW+1))'(ProdW)) && !busy_r;
  end

  assign res_valid = rvalid_r;
  assign res_value = rv_r;
  assign res_ok    = rok_r;
  assign res_inv   = rinv_r;

  assert property (@(posedge clk) disable iff (!rst_n) job_take |=> st_r == ST_SCAN)
    else $error("job taken without scan");
  assert property (@(posedge clk) disable iff (!rst_n) st_r == ST_DONE |=> rvalid_r)
    else $error("result lost");
  assert property (@(posedge clk) disable iff (!rst_n) rvalid_r |-> !job_take)
    else $error("job started with result pending");

endmodule

// File: rtl/core/bidirectional_lut_interpolator.sv
// top level of the bidirectional lut interpolator
//  channel | handshake            | payload
//  in_     | push / full          | operation, entry fields, query_value
//  out_    | pop / empty          | result_value, in_range, was_inverse
//  cfg_    | apb write, pready=1  | entries_in_use at address 0
// a query scans the table entries in a loop, then does a fetch and a multiply,
// then one quotient bit per cycle in the serial divider
// a load waits while any query is queued or in the back end, so it never
// overtakes an earlier query
// reset clears entries_in_use, the job queue and the result valid flag
// the table itself holds whatever was last loaded
// a waiting result stalls the back end only; the front queue keeps taking items until full
module bidirectional_lut_interpolator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_operation,
  input  logic [3:0]           in_entry_index,
  input  logic [15:0]          in_entry_fluence,
  input  logic [15:0]          in_entry_position,
  input  logic [15:0]          in_entry_voltage,
  input  logic [15:0]          in_query_value,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [15:0]          out_result_value,
  output logic                 out_in_range,
  output logic                 out_was_inverse,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [0:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);
  import bli_pkg::*;

  cnt_t  entries_r;
  logic  tbl_we;
  idx_t  tbl_waddr;
  val_t  tbl_wf, tbl_wp, tbl_wv;
  logic  job_valid, job_take, res_valid, res_pop;
  logic  back_busy;
  job_t  job;

  // register write on the access phase of an apb transfer
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) entries_r <= '0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_ENTRIES)
      entries_r <= cnt_t'(cfg_pwdata[4:0]);
  end
  assign cfg_prdata = (cfg_paddr == REG_ENTRIES) ? 32'(entries_r) : '0;

  bli_front u_front (
    .clk, .rst_n,
    .push(in_push), .full(in_full), .op(in_operation),
    .entry_index(in_entry_index), .entry_fluence(in_entry_fluence),
    .entry_position(in_entry_position), .entry_voltage(in_entry_voltage),
    .query_value(in_query_value), .n_cfg(entries_r), .back_busy,
    .tbl_we, .tbl_waddr, .tbl_wf, .tbl_wp, .tbl_wv,
    .job_valid, .job, .job_take
  );

  assign res_pop   = out_pop && res_valid;
  assign out_empty = !res_valid;

  bli_back u_back (
    .clk, .rst_n, .tbl_we, .tbl_waddr, .tbl_wf, .tbl_wp, .tbl_wv,
    .job_valid, .job, .job_take, .busy(back_busy),
    .res_valid, .res_value(out_result_value), .res_ok(out_in_range),
    .res_inv(out_was_inverse), .res_pop
  );

endmodule

// File: bench/bidirectional_lut_interpolator_test.sv
// self-checking testbench for the bidirectional lut interpolator
module bidirectional_lut_interpolator_test;
  import bli_pkg::*;

  localparam int  QuietCycles = 80;
  localparam longint CycleLimit = 4000000;

  typedef struct {
    val_t value;
    bit   in_range;
    bit   inverse;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_operation = OP_NONE;
  logic [3:0]  in_entry_index = '0;
  logic [15:0] in_entry_fluence = '0;
  logic [15:0] in_entry_position = '0;
  logic [15:0] in_entry_voltage = '0;
  logic [15:0] in_query_value = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [15:0] out_result_value;
  logic        out_in_range;
  logic        out_was_inverse;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor copy of the calibration table and entry count
  val_t        key_tab [TableDepth];
  val_t        pos_tab [TableDepth];
  val_t        volt_tab [TableDepth];
  int unsigned entry_count = 0;

  lookup_result_t pending_results [$];

  int     send_idle_pct = 0;
  int     pop_stall_pct = 0;
  int     errors = 0;
  int     items_sent = 0;
  int     queries_sent = 0;
  int     results_seen = 0;
  int     hits_in_range = 0;
  int     tables_loaded = 0;
  longint cycles = 0;

  bidirectional_lut_interpolator uut (.*);

  always #1 clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver side: random stalls on pop
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= pop_stall_pct);
  end

  // compare every result transfer against the oldest prediction
  always @(posedge clk) begin
    lookup_result_t exp_r;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d in_range=%0b inverse=%0b", $time,
                 out_result_value, out_in_range, out_was_inverse);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_result_value !== exp_r.value) begin
          errors++;
          $display("%0t: result_value expected %0d got %0d", $time, exp_r.value,
                   out_result_value);
        end
        if (out_in_range !== exp_r.in_range) begin
          errors++;
          $display("%0t: in_range expected %0b got %0b", $time, exp_r.in_range,
                   out_in_range);
        end
        if (out_was_inverse !== exp_r.inverse) begin
          errors++;
          $display("%0t: was_inverse expected %0b got %0b", $time, exp_r.inverse,
                   out_was_inverse);
        end
      end
    end
  end

  // linear interpolation, product before quotient, quotient truncated
  function automatic val_t interpolate(val_t lo_in, val_t hi_in, val_t lo_out, val_t hi_out,
                                       val_t q);
    longint unsigned span, offs, quot;
    span = hi_in - lo_in;
    offs = q - lo_in;
    if (span == 0) return lo_out;
    if (hi_out >= lo_out) begin
      quot = ((hi_out - lo_out) * offs) / span;
      return val_t'(lo_out + quot);
    end
    quot = ((lo_out - hi_out) * offs) / span;
    return val_t'(lo_out - quot);
  endfunction

  // forward maps key to position, inverse maps voltage to key
  function automatic lookup_result_t calibrate(bit inverse, val_t q);
    lookup_result_t r;
    val_t ins [TableDepth];
    val_t outs [TableDepth];
    int   n, lo_i, hi_i;
    bit   have_lo, have_hi, exact;
    n = (entry_count > TableDepth) ? TableDepth : entry_count;
    r.inverse = inverse;
    r.value = '0;
    r.in_range = 1'b0;
    have_lo = 0;
    have_hi = 0;
    exact = 0;
    lo_i = 0;
    hi_i = 0;
    for (int i = 0; i < TableDepth; i++) begin
      ins[i]  = inverse ? volt_tab[i] : key_tab[i];
      outs[i] = inverse ? key_tab[i] : pos_tab[i];
    end
    if (ins[0] > q || ins[n-1] < q) return r;
    for (int i = 0; i < n; i++) begin
      if (!exact && ins[i] == q) begin
        exact = 1;
        r.value = outs[i];
      end
    end
    if (exact) begin
      r.in_range = 1'b1;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      if (!have_hi && ins[i] > q) begin
        hi_i = i;
        have_hi = 1;
      end
      if (ins[i] < q && (!have_lo || ins[i] > ins[lo_i])) begin
        lo_i = i;
        have_lo = 1;
      end
    end
    if (have_lo && have_hi) begin
      r.in_range = 1'b1;
      r.value = interpolate(ins[lo_i], ins[hi_i], outs[lo_i], outs[hi_i], q);
    end
    return r;
  endfunction

  // wait for every result, then let any resultless query finish
  task automatic wait_quiet();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic send_item(op_t op, logic [3:0] idx, val_t fl, val_t pos, val_t volt,
                           val_t q);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_push           <= 1'b1;
    in_operation      <= op;
    in_entry_index    <= idx;
    in_entry_fluence  <= fl;
    in_entry_position <= pos;
    in_entry_voltage  <= volt;
    in_query_value    <= q;
    do @(posedge clk); while (in_full);
    items_sent++;
    case (op)
      OP_LOAD: begin
        key_tab[idx]  = fl;
        pos_tab[idx]  = pos;
        volt_tab[idx] = volt;
      end
      OP_FWD, OP_INV: begin
        queries_sent++;
        if (entry_count != 0) pending_results.push_back(calibrate(op == OP_INV, q));
      end
      default: ;
    endcase
  endtask

  // loads and count changes only go in while the block is idle
  task automatic load_entry(logic [3:0] idx, val_t fl, val_t pos, val_t volt);
    if (pending_results.size() != 0) wait_quiet();
    send_item(OP_LOAD, idx, fl, pos, volt, val_t'($urandom));
  endtask

  task automatic set_entry_count(int unsigned cnt);
    wait_quiet();
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_ENTRIES;
    cfg_pwdata  <= cnt;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    entry_count = cnt & 5'h1f;
    @(posedge clk);
  endtask

  task automatic test_empty_table();
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'h1234);
    send_item(OP_INV, 4'h0, 16'h0, 16'h0, 16'h0, 16'hffff);
    send_item(OP_NONE, 4'hf, 16'hffff, 16'hffff, 16'hffff, 16'h0);
  endtask

  task automatic test_directed_table();
    // descending voltages, full-scale keys and positions
    load_entry(4'd0, 16'd0, 16'd0, 16'hffff);
    load_entry(4'd1, 16'd1000, 16'hffff, 16'd30000);
    load_entry(4'd2, 16'hffff, 16'd12345, 16'd0);
    set_entry_count(3);
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'd0);
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'hffff);
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'd500);
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'd1000);
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'd30000);
    send_item(OP_INV, 4'h0, 16'h0, 16'h0, 16'h0, 16'hffff);
    send_item(OP_INV, 4'h0, 16'h0, 16'h0, 16'h0, 16'd0);
    send_item(OP_INV, 4'h0, 16'h0, 16'h0, 16'h0, 16'd40000);
    send_item(OP_NONE, 4'h0, 16'h0, 16'h0, 16'h0, 16'd500);
    // one-entry table: only an exact hit is in range
    set_entry_count(1);
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'd0);
    send_item(OP_FWD, 4'h0, 16'h0, 16'h0, 16'h0, 16'd1);
    send_item(OP_INV, 4'h0, 16'h0, 16'h0, 16'h0, 16'd0);
  endtask

  // sorted (or not) table with random content, sometimes crowded for ties
  task automatic load_random_table();
    val_t keys [TableDepth];
    val_t volts [TableDepth];
    val_t t;
    int   base, spread, vmode;
    bit   sorted;
    sorted = ($urandom_range(99) < 80);
    vmode  = $urandom_range(2);
    spread = ($urandom_range(3) == 0) ? 40 : 65535;
    base   = $urandom_range(65535 - spread);
    for (int i = 0; i < TableDepth; i++) begin
      keys[i]  = val_t'(base + $urandom_range(spread));
      volts[i] = val_t'($urandom_range(base, base + spread));
    end
    if (sorted) begin
      for (int i = 1; i < TableDepth; i++)
        for (int j = i; j > 0 && keys[j-1] > keys[j]; j--) begin
          t = keys[j]; keys[j] = keys[j-1]; keys[j-1] = t;
        end
      if (vmode != 0)
        for (int i = 1; i < TableDepth; i++)
          for (int j = i; j > 0 && ((volts[j-1] > volts[j]) == (vmode == 1)); j--) begin
            t = volts[j]; volts[j] = volts[j-1]; volts[j-1] = t;
          end
    end
    for (int i = 0; i < TableDepth; i++)
      load_entry(4'(i), keys[i], val_t'($urandom), volts[i]);
    tables_loaded++;
  endtask

  task automatic test_random_tables(int idle_pct, int stall_pct, int item_budget);
    int   stop_at, n, nq, a, b, pick;
    bit   inverse;
    val_t lo, hi, q;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    stop_at = items_sent + item_budget;
    while (items_sent < stop_at) begin
      load_random_table();
      pick = $urandom_range(19);
      if (pick == 0) set_entry_count($urandom_range(17, 31));
      else if (pick == 1) set_entry_count(1);
      else set_entry_count($urandom_range(2, TableDepth));
      n = (entry_count > TableDepth) ? TableDepth : entry_count;
      nq = $urandom_range(15, 40);
      for (int k = 0; k < nq; k++) begin
        inverse = $urandom_range(1);
        a = $urandom_range(n - 1);
        b = $urandom_range(n - 1);
        lo = inverse ? volt_tab[a] : key_tab[a];
        hi = inverse ? volt_tab[b] : key_tab[b];
        pick = $urandom_range(99);
        if (pick < 60) q = (lo < hi) ? val_t'($urandom_range(lo, hi))
                                     : val_t'($urandom_range(hi, lo));
        else if (pick < 75) q = lo;
        else if (pick < 80) q = val_t'(lo + 1);
        else q = val_t'($urandom);
        if (pick >= 96)
          send_item(OP_NONE, 4'($urandom), val_t'($urandom), val_t'($urandom),
                    val_t'($urandom), q);
        else
          send_item(inverse ? OP_INV : OP_FWD, 4'($urandom), val_t'($urandom),
                    val_t'($urandom), val_t'($urandom), q);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty && out_in_range) hits_in_range++;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_table();
    // no idling, then sender gaps, receiver stalls, and both
    test_random_tables(0, 0, 440);
    test_random_tables(71, 0, 440);
    test_random_tables(0, 71, 440);
    test_random_tables(12, 12, 440);
    set_entry_count(0);
    test_empty_table();
    wait_quiet();
    $display("covered %0d items, %0d queries, %0d results (%0d in range) over %0d tables",
             items_sent, queries_sent, results_seen, hits_in_range, tables_loaded);
    $display("entry counts from empty through saturated, all four idling phases");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
